/* rtl/crq_pkg.sv */
// Package with constants, codes and payload types of the coalescing request queue.
`timescale 1ns / 1ps

package crq_pkg;

  localparam int unsigned QUEUE_SLOTS = 32;
  localparam int unsigned NUM_IDS     = 64;

  localparam int unsigned CELLS  = QUEUE_SLOTS - 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_SLOTS);
  localparam int unsigned IDX_W  = $clog2(NUM_IDS);
  localparam int unsigned ID_W   = 6;
  localparam int unsigned VOL_W  = 8;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 3;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED = 3'd0,
    ST_MERGED = 3'd1,
    ST_UNREG  = 3'd2,
    ST_FULL   = 3'd3,
    ST_POPPED = 3'd4,
    ST_EMPTY  = 3'd5
  } crq_status_e;

  typedef struct packed {
    logic             func;
    logic [ID_W-1:0]  sound_id;
    logic [VOL_W-1:0] volume;
  } crq_in_t;

  typedef struct packed {
    crq_status_e      status;
    logic [ID_W-1:0]  out_id;
    logic [VOL_W-1:0] out_volume;
    logic [OCC_W-1:0] occupancy;
  } crq_out_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic             merge;
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] volume;
  } crq_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] volume;
  } crq_entry_t;

endpackage

/* rtl/coalescing_request_queue.sv */
// Top level of the coalescing request queue: cell row, control and output register.
`timescale 1ns / 1ps

// The result of each accepted item appears in the output register on the next cycle;
// a new item is taken every cycle while that register is empty or being drained.
// Pending requests sit oldest first in a row of QUEUE_SLOTS - 1 cells that compare
// the incoming id in parallel, so a repeated id only updates the stored volume, and
// a pop shifts the whole row by one cell.

module coalescing_request_queue import crq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [NUM_IDS-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  crq_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crq_out_t           out_data_o
);

  logic [NUM_IDS-1:0] registered_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  crq_out_t           out_q, out_d;

  crq_cmd_t   cmd;
  crq_entry_t entries [CELLS];
  logic [CELLS-1:0] match_vec;
  logic [CELLS-1:0] valid_vec;
  logic accept, any_match, id_ok, is_full, is_empty;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign any_match = |match_vec;
  assign is_full   = (count_q == CNT_W'(CELLS));
  assign is_empty  = (count_q == '0);
  assign id_ok     = ({1'b0, in_data_i.sound_id} < (ID_W + 1)'(NUM_IDS)) &&
                     registered_q[in_data_i.sound_id[IDX_W-1:0]];

  always_comb begin
    cmd.pop    = accept && (in_data_i.func == FUNC_DEQ) && !is_empty;
    cmd.merge  = accept && (in_data_i.func == FUNC_ENQ) && id_ok;
    cmd.push   = cmd.merge && !any_match && !is_full;
    cmd.id     = in_data_i.sound_id;
    cmd.volume = in_data_i.volume;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic       prev_valid;
    crq_entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = entries[i-1].valid;
    end
    if (i == CELLS - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end
    crq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_valid_i (prev_valid),
      .next_i       (next_entry),
      .entry_o      (entries[i]),
      .match_o      (match_vec[i])
    );
    assign valid_vec[i] = entries[i].valid;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end else if (cmd.push) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_d            = out_q;
    out_valid_d      = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d      = 1'b1;
      out_d.out_id     = '0;
      out_d.out_volume = '0;
      out_d.occupancy  = OCC_W'(count_d);
      if (in_data_i.func == FUNC_DEQ) begin
        if (is_empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.status     = ST_POPPED;
          out_d.out_id     = entries[0].id;
          out_d.out_volume = entries[0].volume;
        end
      end else if (!id_ok) begin
        out_d.status = ST_UNREG;
      end else if (any_match) begin
        out_d.status = ST_MERGED;
      end else if (is_full) begin
        out_d.status = ST_FULL;
      end else begin
        out_d.status = ST_QUEUED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        registered_q <= cfg_data_i;
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_matches_cells : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_vec)
  ) else $error("Entry count disagrees with the valid cells.");

  a_ids_unique : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec)
  ) else $error("More than one pending entry carries the same id.");

  a_count_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CELLS)
  ) else $error("Entry count exceeds the number of cells.");

  a_accept_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q
  ) else $error("An accepted item produced no result.");

endmodule

/* rtl/crq_cell.sv */
// One queue cell holding a pending request, shifting toward the head on a pop.
`timescale 1ns / 1ps

module crq_cell import crq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  crq_cmd_t   cmd_i,
  input  logic       prev_valid_i,
  input  crq_entry_t next_i,
  output crq_entry_t entry_o,
  output logic       match_o
);

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [VOL_W-1:0] vol_q, vol_d;
  logic             tail;

  assign tail    = !valid_q && prev_valid_i;
  assign match_o = valid_q && (id_q == cmd_i.id);

  always_comb begin
    priority if (cmd_i.pop) begin
      valid_d = next_i.valid;
      id_d    = next_i.id;
      vol_d   = next_i.volume;
    end else if (cmd_i.push && tail) begin
      valid_d = 1'b1;
      id_d    = cmd_i.id;
      vol_d   = cmd_i.volume;
    end else if (cmd_i.merge && match_o) begin
      valid_d = valid_q;
      id_d    = id_q;
      vol_d   = cmd_i.volume;
    end else begin
      valid_d = valid_q;
      id_d    = id_q;
      vol_d   = vol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    vol_q <= vol_d;
  end

  assign entry_o = '{valid: valid_q, id: id_q, volume: vol_q};

endmodule
